@@ rtl/tkls_pkg.sv @@
// Shared types and sizing constants for the top-k logit selector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tkls_pkg;

	localparam int MAX_K   = 16;
	localparam int MAX_ROW = 131072;

	localparam int LOGIT_W = 16;
	localparam int TOP_W   = 5;
	localparam int IDX_W   = $clog2(MAX_ROW);
	localparam int CNT_W   = $clog2(MAX_K + 1);
	localparam int CMP_W   = (CNT_W > TOP_W) ? CNT_W : TOP_W;

	localparam logic [IDX_W-1:0] ROW_LAST = IDX_W'(MAX_ROW - 1);
	localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(MAX_K);

	typedef enum logic [1:0] {
		ST_ACCEPT = 2'b01,
		ST_EMIT   = 2'b10
	} tkls_state_t;

	// controller -> datapath
	typedef struct packed {
		logic insert;   // insert the accepted logit into the kept list
		logic row_done; // row_end beat: reset row counters, load emit count
		logic pop;      // move head of list into the output register
	} tkls_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;  // output register can take a beat this cycle
		logic emit_last; // the pending pop is the final one of the row
		logic emit_none; // the row ending now emits nothing
	} tkls_stat_t;

endpackage

@@ rtl/tkls_ctrl.sv @@
// Controller for the top-k logit selector: accept / emit sequencing.
// Depends on tkls_pkg for the state and command/status types.
`timescale 1ns / 1ps

module tkls_ctrl
	import tkls_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       row_end,
	output logic       in_ready,
	input  tkls_stat_t stat,
	output tkls_cmd_t  cmd
);

	tkls_state_t state_q, state_d;
	logic        in_fire;

	assign in_ready = (state_q == ST_ACCEPT);
	assign in_fire  = in_valid & in_ready;

	always_comb begin
		state_d      = state_q;
		cmd.insert   = 1'b0;
		cmd.row_done = 1'b0;
		cmd.pop      = 1'b0;
		unique case (state_q)
			ST_ACCEPT: begin
				cmd.insert   = in_fire;
				cmd.row_done = in_fire & row_end;
				if (in_fire && row_end && !stat.emit_none) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.pop = stat.out_free;
				if (stat.out_free && stat.emit_last) begin
					state_d = ST_ACCEPT;
				end
			end
			default: state_d = ST_ACCEPT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCEPT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/tkls_datapath.sv @@
// Datapath for the top-k logit selector: sorted kept list with
// compare-and-shift insertion, row counters, k register and output register.
// Depends on tkls_pkg.
`timescale 1ns / 1ps

module tkls_datapath
	import tkls_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic [TOP_W-1:0]          top_count,
	input  logic signed [LOGIT_W-1:0] logit,
	input  tkls_cmd_t                 cmd,
	output tkls_stat_t                stat,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [LOGIT_W-1:0] out_logit,
	output logic [IDX_W-1:0]          token_index,
	output logic                      run_last,
	output logic                      short_row
);

	logic [TOP_W-1:0]          top_q;
	logic [CNT_W-1:0]          fill_q;
	logic [IDX_W-1:0]          pos_q;
	logic [CNT_W-1:0]          emit_left_q;
	logic                      short_q;
	logic                      out_valid_q;

	logic signed [LOGIT_W-1:0] kept_val_q [MAX_K];
	logic [IDX_W-1:0]          kept_idx_q [MAX_K];
	logic signed [LOGIT_W-1:0] ins_val    [MAX_K];
	logic [IDX_W-1:0]          ins_idx    [MAX_K];
	logic [MAX_K-1:0]          keep;

	logic [CNT_W-1:0]          fill_next;
	logic [CMP_W-1:0]          k_sat;
	logic                      short_next;
	logic [CNT_W-1:0]          emit_n;

	// entries that stay in place: valid and not below the new logit (ties keep
	// arrival order); the list is sorted so this is a prefix
	always_comb begin
		for (int i = 0; i < MAX_K; i++) begin
			keep[i] = (CNT_W'(i) < fill_q) && (kept_val_q[i] >= logit);
		end
		ins_val[0] = keep[0] ? kept_val_q[0] : logit;
		ins_idx[0] = keep[0] ? kept_idx_q[0] : pos_q;
		for (int i = 1; i < MAX_K; i++) begin
			if (keep[i]) begin
				ins_val[i] = kept_val_q[i];
				ins_idx[i] = kept_idx_q[i];
			end else if (keep[i-1]) begin
				ins_val[i] = logit;
				ins_idx[i] = pos_q;
			end else begin
				ins_val[i] = kept_val_q[i-1];
				ins_idx[i] = kept_idx_q[i-1];
			end
		end
	end

	assign fill_next  = (fill_q < FILL_MAX) ? fill_q + CNT_W'(1) : fill_q;
	assign k_sat      = (CMP_W'(top_q) > CMP_W'(MAX_K)) ? CMP_W'(MAX_K) : CMP_W'(top_q);
	assign short_next = CMP_W'(fill_next) < k_sat;
	assign emit_n     = short_next ? fill_next : CNT_W'(k_sat);

	assign stat.out_free  = !out_valid_q || out_ready;
	assign stat.emit_last = (emit_left_q == CNT_W'(1));
	assign stat.emit_none = (emit_n == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q       <= TOP_W'(1);
			fill_q      <= '0;
			pos_q       <= '0;
			emit_left_q <= '0;
			short_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				top_q <= top_count;
			end
			if (cmd.row_done) begin
				fill_q      <= '0;
				pos_q       <= '0;
				emit_left_q <= emit_n;
				short_q     <= short_next;
			end else if (cmd.insert) begin
				fill_q <= fill_next;
				if (pos_q != ROW_LAST) begin
					pos_q <= pos_q + IDX_W'(1);
				end
			end
			if (cmd.pop) begin
				emit_left_q <= emit_left_q - CNT_W'(1);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// list payload and output payload: no reset
	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			for (int i = 0; i < MAX_K; i++) begin
				kept_val_q[i] <= ins_val[i];
				kept_idx_q[i] <= ins_idx[i];
			end
		end else if (cmd.pop) begin
			for (int i = 0; i < MAX_K - 1; i++) begin
				kept_val_q[i] <= kept_val_q[i+1];
				kept_idx_q[i] <= kept_idx_q[i+1];
			end
		end
		if (cmd.pop) begin
			out_logit   <= kept_val_q[0];
			token_index <= kept_idx_q[0];
			run_last    <= (emit_left_q == CNT_W'(1));
			short_row   <= short_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/top_k_logit_selector_core.sv @@
// Top level of the top-k logit selector.
// Depends on tkls_pkg, tkls_ctrl and tkls_datapath.
//
// Usage:
//  - Input channel (in_valid/in_ready, logit, row_end): one Q8.8 logit per
//    beat; row_end marks the row's last beat. While a row is streaming in,
//    in_ready is high and one beat is taken every cycle.
//  - Output channel (out_valid/out_ready): on a row_end beat the k largest
//    logits with their row positions follow in descending order, ties by
//    lower position; run_last marks the final beat, short_row is set on all
//    beats of a row that held fewer than k logits. k of zero emits nothing.
//  - Config channel (cfg_valid/cfg_ready, top_count): sets k, saturated at 16;
//    always ready, write only while idle.
//  - Emit sequence: the row_end beat sets the emit state; each pop then moves
//    the list head into the output register, one result per cycle while the
//    receiver is ready. The kept list is shifted out through the single
//    output register, so input is held off until the row's last pop, and
//    longer if the receiver stalls, which freezes the list and the output beat.
//  - Reset: k = 1, kept list empty, row position 0, no result pending.
`timescale 1ns / 1ps

module top_k_logit_selector_core
	import tkls_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [TOP_W-1:0]          top_count,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [LOGIT_W-1:0] logit,
	input  logic                      row_end,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [LOGIT_W-1:0] out_logit,
	output logic [IDX_W-1:0]          token_index,
	output logic                      run_last,
	output logic                      short_row
);

	tkls_cmd_t  cmd;
	tkls_stat_t stat;

	assign cfg_ready = 1'b1;

	tkls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.row_end  (row_end),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tkls_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.top_count   (top_count),
		.logit       (logit),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_logit   (out_logit),
		.token_index (token_index),
		.run_last    (run_last),
		.short_row   (short_row)
	);

endmodule
